>>> rtl/tbf_pkg.sv
// Shared types and constants for the tape block framer.
// No dependencies; imported by every module of the block.
`default_nettype none

package tbf_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_HEADERLESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILE_TYPE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_LO    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_HI    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_LEN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PARAM_ONE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PARAM_TWO  = 3'd6;

  localparam logic [15:0] LEN_MAX      = 16'd65533;
  localparam logic [15:0] HDR_BLK_LEN  = 16'd19;
  localparam logic [7:0]  FLAG_HEADER  = 8'h00;
  localparam logic [7:0]  FLAG_DATA    = 8'hFF;
  localparam logic [63:0] NAME_LO_RST  = 64'h2020_2020_2020_2020;
  localparam logic [15:0] NAME_HI_RST  = 16'h2020;

  // byte positions within the start burst
  localparam int unsigned POS_W = 5;
  localparam logic [POS_W-1:0] POS_LEN_LO    = 5'd0;
  localparam logic [POS_W-1:0] POS_LEN_HI    = 5'd1;
  localparam logic [POS_W-1:0] POS_FLAG_HDR  = 5'd2;
  localparam logic [POS_W-1:0] POS_TYPE      = 5'd3;
  localparam logic [POS_W-1:0] POS_NAME      = 5'd4;
  localparam logic [POS_W-1:0] POS_NAME_END  = 5'd13;
  localparam logic [POS_W-1:0] POS_SIZE_LO   = 5'd14;
  localparam logic [POS_W-1:0] POS_SIZE_HI   = 5'd15;
  localparam logic [POS_W-1:0] POS_P1_LO     = 5'd16;
  localparam logic [POS_W-1:0] POS_P1_HI     = 5'd17;
  localparam logic [POS_W-1:0] POS_P2_LO     = 5'd18;
  localparam logic [POS_W-1:0] POS_P2_HI     = 5'd19;
  localparam logic [POS_W-1:0] POS_HDR_CHK   = 5'd20;
  localparam logic [POS_W-1:0] POS_DLEN_LO   = 5'd21;
  localparam logic [POS_W-1:0] POS_DLEN_HI   = 5'd22;
  localparam logic [POS_W-1:0] POS_FLAG_DATA = 5'd23;
  localparam logic [POS_W-1:0] POS_DATA_CHK  = 5'd24;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_DATA,
    CMD_DATA_LAST,
    CMD_MISUSE
  } cmd_kind_t;

  typedef enum logic {
    PH_IDLE,
    PH_OPEN
  } phase_t;

  typedef struct packed {
    logic        headerless;
    logic [7:0]  file_type;
    logic [79:0] name;
    logic [15:0] data_length;
    logic [15:0] param_one;
    logic [15:0] param_two;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic [7:0] data_byte;
    logic [7:0] chk;
    cfg_t       cfg;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/tbf_front.sv
// Front end: accepts input words, tracks frame state, emits one command per word.
// Depends on tbf_pkg.
`default_nettype none

module tbf_front
  import tbf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic       req_type,
  input  wire logic [7:0] data_byte,
  input  wire cfg_t       cfg,
  output cmd_t            cmd
);

  phase_t      phase, phase_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [7:0]  xor_upd;

  assign xor_upd = running_xor ^ data_byte;

  always_comb begin
    phase_next       = phase;
    bytes_left_next  = bytes_left;
    running_xor_next = running_xor;
    if (accept) begin
      unique case (phase)
        PH_IDLE: begin
          if (!req_type) begin
            bytes_left_next = cfg.data_length;
            if (cfg.data_length == 16'd0) begin
              running_xor_next = 8'h00;
            end else begin
              phase_next       = PH_OPEN;
              running_xor_next = FLAG_DATA;
            end
          end
        end
        PH_OPEN: begin
          if (req_type) begin
            bytes_left_next = bytes_left - 16'd1;
            if (bytes_left == 16'd1) begin
              phase_next       = PH_IDLE;
              running_xor_next = 8'h00;
            end else begin
              running_xor_next = xor_upd;
            end
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.data_byte = data_byte;
    cmd.chk       = xor_upd;
    cmd.cfg       = cfg;
    cmd.kind      = CMD_MISUSE;
    unique case (phase)
      PH_IDLE: cmd.kind = req_type ? CMD_MISUSE : CMD_START;
      PH_OPEN: begin
        if (!req_type) begin
          cmd.kind = CMD_MISUSE;
        end else if (bytes_left == 16'd1) begin
          cmd.kind = CMD_DATA_LAST;
        end else begin
          cmd.kind = CMD_DATA;
        end
      end
      default: cmd.kind = CMD_MISUSE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bytes_left  <= 16'd0;
      running_xor <= 8'h00;
    end else begin
      phase       <= phase_next;
      bytes_left  <= bytes_left_next;
      running_xor <= running_xor_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tbf_fifo.sv
// Small register queue carrying commands from front end to back end.
// Depends on tbf_pkg.
`default_nettype none

module tbf_fifo
  import tbf_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      full,
  output logic      empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/tbf_back.sv
// Back end: expands queued commands into output words, one per cycle while the output register is empty or popped.
// Depends on tbf_pkg.
`default_nettype none

module tbf_back
  import tbf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cmd_t       head,
  input  wire logic       head_empty,
  output logic            head_pop,
  input  wire logic       pop,
  output logic            empty,
  output logic [7:0]      out_byte,
  output logic            run_last,
  output logic            frame_end,
  output logic            misuse
);

  logic [POS_W-1:0] idx, idx_next, cur_idx;
  logic             out_valid, load;
  logic [7:0]       b, start_b, hdr_chk, name_b;
  logic             b_last, b_fe, b_mis;
  logic [3:0]       name_sel;
  logic [6:0]       name_bit;
  logic [15:0]      dlen_plus;

  assign cur_idx = (idx == POS_LEN_LO && head.kind == CMD_START && head.cfg.headerless)
                   ? POS_DLEN_LO : idx;
  assign name_sel  = 4'(cur_idx - POS_NAME);
  assign name_bit  = {name_sel, 3'b000};
  assign name_b    = head.cfg.name[name_bit +: 8];
  assign dlen_plus = head.cfg.data_length + 16'd2;

  always_comb begin
    hdr_chk = FLAG_HEADER ^ head.cfg.file_type;
    for (int i = 0; i < 10; i++) begin
      hdr_chk = hdr_chk ^ head.cfg.name[8*i +: 8];
    end
    hdr_chk = hdr_chk ^ head.cfg.data_length[7:0] ^ head.cfg.data_length[15:8]
            ^ head.cfg.param_one[7:0] ^ head.cfg.param_one[15:8]
            ^ head.cfg.param_two[7:0] ^ head.cfg.param_two[15:8];
  end

  always_comb begin
    priority if (cur_idx == POS_LEN_LO)       start_b = HDR_BLK_LEN[7:0];
    else if (cur_idx == POS_LEN_HI)           start_b = HDR_BLK_LEN[15:8];
    else if (cur_idx == POS_FLAG_HDR)         start_b = FLAG_HEADER;
    else if (cur_idx == POS_TYPE)             start_b = head.cfg.file_type;
    else if (cur_idx <= POS_NAME_END)         start_b = name_b;
    else if (cur_idx == POS_SIZE_LO)          start_b = head.cfg.data_length[7:0];
    else if (cur_idx == POS_SIZE_HI)          start_b = head.cfg.data_length[15:8];
    else if (cur_idx == POS_P1_LO)            start_b = head.cfg.param_one[7:0];
    else if (cur_idx == POS_P1_HI)            start_b = head.cfg.param_one[15:8];
    else if (cur_idx == POS_P2_LO)            start_b = head.cfg.param_two[7:0];
    else if (cur_idx == POS_P2_HI)            start_b = head.cfg.param_two[15:8];
    else if (cur_idx == POS_HDR_CHK)          start_b = hdr_chk;
    else if (cur_idx == POS_DLEN_LO)          start_b = dlen_plus[7:0];
    else if (cur_idx == POS_DLEN_HI)          start_b = dlen_plus[15:8];
    else                                      start_b = FLAG_DATA;
  end

  always_comb begin
    b      = 8'h00;
    b_last = 1'b1;
    b_fe   = 1'b0;
    b_mis  = 1'b0;
    unique case (head.kind)
      CMD_START: begin
        b      = start_b;
        b_fe   = (cur_idx == POS_DATA_CHK);
        b_last = (cur_idx == POS_DATA_CHK) ||
                 (cur_idx == POS_FLAG_DATA && head.cfg.data_length != 16'd0);
      end
      CMD_DATA: b = head.data_byte;
      CMD_DATA_LAST: begin
        if (idx == POS_LEN_LO) begin
          b      = head.data_byte;
          b_last = 1'b0;
        end else begin
          b    = head.chk;
          b_fe = 1'b1;
        end
      end
      CMD_MISUSE: b_mis = 1'b1;
      default: b_mis = 1'b1;
    endcase
  end

  assign load     = !head_empty && (!out_valid || pop);
  assign head_pop = load && b_last;
  assign empty    = !out_valid;

  always_comb begin
    idx_next = idx;
    if (load) begin
      idx_next = b_last ? POS_LEN_LO : cur_idx + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= POS_LEN_LO;
      out_valid <= 1'b0;
    end else begin
      idx <= idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= b;
      run_last  <= b_last;
      frame_end <= b_fe;
      misuse    <= b_mis;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tape_block_framer_xor.sv
// Top level of the tape block framer: config registers, front end, queue, back end.
// Depends on tbf_pkg, tbf_front, tbf_fifo, tbf_back.
`default_nettype none

// Frames a byte stream as tape-image blocks. A start word produces the 21-byte
// header block (unless headerless) and the 3-byte data-block prefix, each data
// word produces its byte, and the last one also the closing XOR checksum, which
// a start word with zero data length also gives. The front end takes one word
// per cycle into a command queue of FIFO_DEPTH entries while it is not full;
// the back end writes one result word per cycle into the output register while
// that is empty or being popped, so a start word holds the back end for one word
// per byte it yields, while the queue absorbs further words. Registers are
// sampled when the start word is taken; config writes are meant for idle periods.

module tape_block_framer_xor
  import tbf_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic                  req_type,
  input  wire logic [7:0]            data_byte,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [7:0]                 out_byte,
  output logic                       run_last,
  output logic                       frame_end,
  output logic                       misuse,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  cmd_t front_cmd, head;
  logic accept, head_empty, head_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.headerless  <= 1'b0;
      cfg.file_type   <= 8'h00;
      cfg.name        <= {NAME_HI_RST, NAME_LO_RST};
      cfg.data_length <= 16'd0;
      cfg.param_one   <= 16'd0;
      cfg.param_two   <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADERLESS: cfg.headerless <= cfg_data[0];
        REG_FILE_TYPE:  cfg.file_type <= cfg_data[7:0];
        REG_NAME_LO:    cfg.name[63:0] <= cfg_data;
        REG_NAME_HI:    cfg.name[79:64] <= cfg_data[15:0];
        REG_DATA_LEN:   cfg.data_length <= (cfg_data[15:0] > LEN_MAX) ? LEN_MAX
                                                                      : cfg_data[15:0];
        REG_PARAM_ONE:  cfg.param_one <= cfg_data[15:0];
        REG_PARAM_TWO:  cfg.param_two <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  tbf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req_type  (req_type),
    .data_byte (data_byte),
    .cfg       (cfg),
    .cmd       (front_cmd)
  );

  tbf_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_cmd (front_cmd),
    .pop      (head_pop),
    .head     (head),
    .full     (full),
    .empty    (head_empty)
  );

  tbf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_empty (head_empty),
    .head_pop   (head_pop),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .frame_end  (frame_end),
    .misuse     (misuse)
  );

  a_misuse_word : assert property (@(posedge clk) disable iff (rst)
    !empty && misuse |-> out_byte == 8'h00 && run_last && !frame_end)
    else $error("misuse word malformed");

  a_frame_end_last : assert property (@(posedge clk) disable iff (rst)
    !empty && frame_end |-> run_last)
    else $error("checksum word is not the last of its run");

  a_empty_after_rst : assert property (@(posedge clk)
    $past(rst) |-> empty && !full)
    else $error("queues not cleared by reset");

endmodule

`default_nettype wire
